// ===== rtl/four_axis_step_dir_interpolator_core_defines.svh =====
// Assertion macros for the four-axis step/direction interpolator.
// Used by the top level only; define NO_ASSERTIONS to compile them out.
`ifndef FOUR_AXIS_STEP_DIR_INTERPOLATOR_CORE_DEFINES_SVH
`define FOUR_AXIS_STEP_DIR_INTERPOLATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FASDI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FASDI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FASDI_ASSERT(label, prop, msg)
`define FASDI_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/fasdi_pkg.sv =====
// Shared types and constants of the four-axis step/direction interpolator.
// No dependencies; imported by the lane, merge and top-level modules.
`timescale 1ns / 1ps
package fasdi_pkg;

   localparam int AXES        = 4;
   localparam int PERIOD_BITS = 16;
   localparam int SPR_BITS    = 16;
   localparam int GEAR_BITS   = 8;
   localparam int SCALE_BITS  = SPR_BITS + GEAR_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_PERIOD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEPS_PER_REV = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GEAR_RATIO    = 2'd2;

   localparam logic [PERIOD_BITS-1:0] RESET_BASE_PERIOD   = 16'd150;
   localparam logic [SPR_BITS-1:0]    RESET_STEPS_PER_REV = 16'd3200;
   localparam logic [GEAR_BITS-1:0]   RESET_GEAR_RATIO    = 8'd1;
   localparam logic [PERIOD_BITS-1:0] RESET_STEP_PERIOD   = 16'd150;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // sequencer strobes to every lane and the merge stage
   typedef struct packed {
      logic move_start;
      logic tick;
      logic mul2;
      logic diff;
      logic max;
      logic load;
      logic div;
      logic commit;
   } lane_cmd_type;

   typedef struct packed {
      logic step;
      logic dir;
      logic active;
   } lane_stat_type;

endpackage

// ===== rtl/fasdi_lane.sv =====
// One axis: angle scaling, distance, radix-4 period divider and tick counter.
// Depends on fasdi_pkg.
`timescale 1ns / 1ps
module fasdi_lane
   import fasdi_pkg::*;
#(
   parameter int ANGLE_BITS     = 12,
   parameter int POSITION_BITS  = 16,
   parameter int COMPARE_OFFSET = 50
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lane_cmd_type                           cmd,
   input  logic [ANGLE_BITS-1:0]                  angle,
   input  logic [SPR_BITS-1:0]                    steps_per_rev,
   input  logic [GEAR_BITS-1:0]                   gear_ratio,
   input  logic [PERIOD_BITS+POSITION_BITS-1:0]   num,
   output logic [POSITION_BITS-1:0]               axis_dist,
   output lane_stat_type                          stat
);

   localparam int P1_BITS   = ANGLE_BITS + SPR_BITS;
   localparam int P2_BITS   = P1_BITS + GEAR_BITS;
   localparam int NUM_BITS  = PERIOD_BITS + POSITION_BITS;
   localparam int DIV_ITERS = (NUM_BITS + 1) / 2;
   localparam int DIV_BITS  = 2 * DIV_ITERS;
   localparam logic [PERIOD_BITS-1:0] CMP_POINT = PERIOD_BITS'(COMPARE_OFFSET);
   localparam logic [PERIOD_BITS-1:0] MIN_PERIOD = PERIOD_BITS'(COMPARE_OFFSET + 1);

   // datapath registers
   logic [P1_BITS-1:0]       prod1_ff, prod1_in;
   logic [P2_BITS-1:0]       prod2_ff, prod2_in;
   logic [POSITION_BITS-1:0] dist_ff, dist_in;
   logic [DIV_BITS-1:0]      quo_ff, quo_in;
   logic [POSITION_BITS-1:0] rem_ff, rem_in;

   // axis state
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] target_ff, target_in;
   logic                     dir_ff, dir_in;
   logic [PERIOD_BITS-1:0]   period_ff, period_in;
   logic [PERIOD_BITS-1:0]   tick_ff, tick_in;
   logic                     active_ff, active_in;
   logic                     step_ff, step_in;

   logic [SCALE_BITS-1:0]    scaled;
   logic [POSITION_BITS-1:0] target_sat;
   logic [POSITION_BITS:0]   r1, r1_sub, r2, r2_sub;
   logic                     q1, q2;
   logic [POSITION_BITS-1:0] rem_mid;
   logic [PERIOD_BITS-1:0]   quo_sat, period_new;
   logic [PERIOD_BITS:0]     tick_inc;
   logic [PERIOD_BITS-1:0]   tick_adv;
   logic [POSITION_BITS-1:0] pos_step, pos_after;

   assign scaled = prod2_ff[P2_BITS-1:ANGLE_BITS];

   generate
      if (POSITION_BITS < SCALE_BITS) begin : g_sat
         assign target_sat = (|scaled[SCALE_BITS-1:POSITION_BITS]) ? '1
                                                                     : scaled[POSITION_BITS-1:0];
      end else begin : g_nosat
         assign target_sat = POSITION_BITS'(scaled);
      end
   endgenerate

   // two restoring division steps per cycle
   always_comb begin
      r1      = {rem_ff, quo_ff[DIV_BITS-1]};
      r1_sub  = r1 - {1'b0, dist_ff};
      q1      = (r1 >= {1'b0, dist_ff});
      rem_mid = q1 ? r1_sub[POSITION_BITS-1:0] : r1[POSITION_BITS-1:0];
      r2      = {rem_mid, quo_ff[DIV_BITS-2]};
      r2_sub  = r2 - {1'b0, dist_ff};
      q2      = (r2 >= {1'b0, dist_ff});
   end

   always_comb begin
      quo_sat    = (|quo_ff[DIV_BITS-1:PERIOD_BITS]) ? '1 : quo_ff[PERIOD_BITS-1:0];
      period_new = (quo_sat <= CMP_POINT) ? MIN_PERIOD : quo_sat;
   end

   always_comb begin
      tick_inc  = {1'b0, tick_ff} + {{PERIOD_BITS{1'b0}}, 1'b1};
      tick_adv  = (tick_inc >= {1'b0, period_ff}) ? '0 : tick_inc[PERIOD_BITS-1:0];
      pos_step  = dir_ff ? position_ff + 1'b1 : position_ff - 1'b1;
      pos_after = (position_ff != target_ff) ? pos_step : position_ff;
   end

   always_comb begin
      prod1_in = prod1_ff;
      prod2_in = prod2_ff;
      dist_in  = dist_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (cmd.move_start) begin
         prod1_in = P1_BITS'(angle) * P1_BITS'(steps_per_rev);
      end
      if (cmd.mul2) begin
         prod2_in = P2_BITS'(prod1_ff) * P2_BITS'(gear_ratio);
      end
      if (cmd.diff) begin
         dist_in = (target_sat >= position_ff) ? target_sat - position_ff
                                               : position_ff - target_sat;
      end
      if (cmd.load) begin
         quo_in = DIV_BITS'(num);
         rem_in = '0;
      end else if (cmd.div) begin
         quo_in = {quo_ff[DIV_BITS-3:0], q1, q2};
         rem_in = q2 ? r2_sub[POSITION_BITS-1:0] : r2[POSITION_BITS-1:0];
      end
   end

   always_comb begin
      position_in = position_ff;
      target_in   = target_ff;
      dir_in      = dir_ff;
      period_in   = period_ff;
      tick_in     = tick_ff;
      active_in   = active_ff;
      step_in     = step_ff;
      if (cmd.move_start) begin
         step_in = 1'b0;
      end
      if (cmd.diff) begin
         target_in = target_sat;
      end
      if (cmd.commit) begin
         tick_in = '0;
         if (dist_ff != '0) begin
            period_in = period_new;
            dir_in    = (target_ff > position_ff);
            active_in = 1'b1;
         end else begin
            active_in = 1'b0;
         end
      end
      if (cmd.tick) begin
         step_in = 1'b0;
         if (active_ff) begin
            tick_in = tick_adv;
            if (tick_adv == CMP_POINT) begin
               step_in     = (position_ff != target_ff);
               position_in = pos_after;
               active_in   = (pos_after != target_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      dist_ff  <= dist_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         target_ff   <= '0;
         dir_ff      <= 1'b0;
         period_ff   <= RESET_STEP_PERIOD;
         tick_ff     <= '0;
         active_ff   <= 1'b0;
         step_ff     <= 1'b0;
      end else begin
         position_ff <= position_in;
         target_ff   <= target_in;
         dir_ff      <= dir_in;
         period_ff   <= period_in;
         tick_ff     <= tick_in;
         active_ff   <= active_in;
         step_ff     <= step_in;
      end
   end

   assign axis_dist   = dist_ff;
   assign stat.step   = step_ff;
   assign stat.dir    = dir_ff;
   assign stat.active = active_ff;

endmodule

// ===== rtl/fasdi_merge.sv =====
// Merge stage: largest distance over the lanes, period numerator, busy flag.
// Depends on fasdi_pkg.
`timescale 1ns / 1ps
module fasdi_merge
   import fasdi_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic                                         clock,
   input  lane_cmd_type                                 cmd,
   input  logic [AXES-1:0][POSITION_BITS-1:0]           lane_dist,
   input  logic [AXES-1:0]                              lane_active,
   input  logic [PERIOD_BITS-1:0]                       base_period,
   output logic [PERIOD_BITS+POSITION_BITS-1:0]         num,
   output logic                                         busy
);

   localparam int NUM_BITS = PERIOD_BITS + POSITION_BITS;

   logic [POSITION_BITS-1:0] gm_ff, gm_in, gm_max;

   always_comb begin
      gm_max = '0;
      for (int i = 0; i < AXES; i++) begin
         if (lane_dist[i] > gm_max) begin
            gm_max = lane_dist[i];
         end
      end
      gm_in = cmd.max ? gm_max : gm_ff;
   end

   always_ff @(posedge clock) begin
      gm_ff <= gm_in;
   end

   // base_period * largest distance, loaded into every lane divider
   assign num  = NUM_BITS'(base_period) * NUM_BITS'(gm_ff);
   assign busy = |lane_active;

endmodule

// ===== rtl/four_axis_step_dir_interpolator_core.sv =====
// Four-axis step/direction interpolator, top level; uses fasdi_pkg, fasdi_lane,
// fasdi_merge and the assertion macros in four_axis_step_dir_interpolator_core_defines.svh.
// Each request transaction is either a move (opcode 0) carrying four target angles or a
// timer tick (opcode 1); each produces exactly one response transaction with the step
// pulses of that tick (always zero for a move), the four direction bits and a busy flag.
// A move scales every angle by steps_per_rev * gear_ratio / 2^ANGLE_BITS (saturated),
// then gives each moving axis a period of base_period * largest distance / own distance
// so all axes arrive together; an axis already at its target goes idle. Four lanes run
// side by side, one per axis, and a merge stage finds the largest distance and the busy
// flag. A tick updates the lanes on the accepting edge, then loads the response register.
// A move does its first multiply on acceptance, then steps through the second multiply,
// distance, maximum, divider load, radix-4 restoring divide and commit states, then loads
// the response register. One transaction is in flight at a time; the response sits in its
// own register, so a new request is taken while an earlier response waits, but the
// following response is held until that one has gone. Configuration writes are always
// ready and take effect at once; they should only be made while idle.
`timescale 1ns / 1ps
`include "four_axis_step_dir_interpolator_core_defines.svh"
module four_axis_step_dir_interpolator_core
   import fasdi_pkg::*;
#(
   parameter int ANGLE_BITS     = 12,
   parameter int POSITION_BITS  = 16,
   parameter int COMPARE_OFFSET = 50
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [ANGLE_BITS-1:0]     req_angle_axis0,
   input  logic [ANGLE_BITS-1:0]     req_angle_axis1,
   input  logic [ANGLE_BITS-1:0]     req_angle_axis2,
   input  logic [ANGLE_BITS-1:0]     req_angle_axis3,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_step_axis0,
   output logic                      rsp_step_axis1,
   output logic                      rsp_step_axis2,
   output logic                      rsp_step_axis3,
   output logic                      rsp_dir_axis0,
   output logic                      rsp_dir_axis1,
   output logic                      rsp_dir_axis2,
   output logic                      rsp_dir_axis3,
   output logic                      rsp_busy_res,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int NUM_BITS     = PERIOD_BITS + POSITION_BITS;
   localparam int DIV_ITERS    = (NUM_BITS + 1) / 2;
   localparam int DIV_CNT_BITS = $clog2(DIV_ITERS);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL2   = 3'd1;
   localparam logic [2:0] ST_DIST   = 3'd2;
   localparam logic [2:0] ST_MAX    = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_COMMIT = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;

   logic [PERIOD_BITS-1:0]  base_period_ff, base_period_in;
   logic [SPR_BITS-1:0]     spr_ff, spr_in;
   logic [GEAR_BITS-1:0]    gear_ff, gear_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AXES-1:0]         rsp_step_ff, rsp_step_in;
   logic [AXES-1:0]         rsp_dir_ff, rsp_dir_in;
   logic                    rsp_busy_ff, rsp_busy_in;

   logic                    req_accept;
   logic                    rsp_load;
   lane_cmd_type            cmd;

   logic [AXES-1:0][ANGLE_BITS-1:0]    lane_angle;
   logic [AXES-1:0][POSITION_BITS-1:0] lane_dist;
   lane_stat_type                      lane_stat [AXES];
   logic [AXES-1:0]                    lane_step, lane_dir, lane_active;
   logic [NUM_BITS-1:0]                merge_num;
   logic                               merge_busy;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign lane_angle[0] = req_angle_axis0;
   assign lane_angle[1] = req_angle_axis1;
   assign lane_angle[2] = req_angle_axis2;
   assign lane_angle[3] = req_angle_axis3;

   // the first multiply of a move, and a whole tick, happen on the accepting edge
   always_comb begin
      cmd.move_start = req_accept && (req_opcode == OP_MOVE);
      cmd.tick       = req_accept && (req_opcode == OP_TICK);
      cmd.mul2       = (state_ff == ST_MUL2);
      cmd.diff       = (state_ff == ST_DIST);
      cmd.max        = (state_ff == ST_MAX);
      cmd.load       = (state_ff == ST_LOAD);
      cmd.div        = (state_ff == ST_DIV);
      cmd.commit     = (state_ff == ST_COMMIT);
   end

   // response register frees when empty or being taken this cycle
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_opcode == OP_MOVE) ? ST_MUL2 : ST_FINISH;
            end
         end
         ST_MUL2:   state_in = ST_DIST;
         ST_DIST:   state_in = ST_MAX;
         ST_MAX:    state_in = ST_LOAD;
         ST_LOAD: begin
            state_in   = ST_DIV;
            div_cnt_in = DIV_CNT_BITS'(DIV_ITERS - 1);
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         ST_COMMIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      base_period_in = base_period_ff;
      spr_in         = spr_ff;
      gear_in        = gear_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_PERIOD:   base_period_in = csr_wdata;
            CSR_STEPS_PER_REV: spr_in         = csr_wdata;
            CSR_GEAR_RATIO:    gear_in        = csr_wdata[GEAR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         lane_step[i]   = lane_stat[i].step;
         lane_dir[i]    = lane_stat[i].dir;
         lane_active[i] = lane_stat[i].active;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_busy_in  = rsp_busy_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_step_in  = lane_step;
         rsp_dir_in   = lane_dir;
         rsp_busy_in  = merge_busy;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         div_cnt_ff     <= '0;
         base_period_ff <= RESET_BASE_PERIOD;
         spr_ff         <= RESET_STEPS_PER_REV;
         gear_ff        <= RESET_GEAR_RATIO;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         div_cnt_ff     <= div_cnt_in;
         base_period_ff <= base_period_in;
         spr_ff         <= spr_in;
         gear_ff        <= gear_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_step_ff <= rsp_step_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   generate
      for (genvar g = 0; g < AXES; g++) begin : g_lane
         fasdi_lane #(
            .ANGLE_BITS     (ANGLE_BITS),
            .POSITION_BITS  (POSITION_BITS),
            .COMPARE_OFFSET (COMPARE_OFFSET)
         ) u_lane (
            .clock          (clock),
            .reset          (reset),
            .cmd            (cmd),
            .angle          (lane_angle[g]),
            .steps_per_rev  (spr_ff),
            .gear_ratio     (gear_ff),
            .num            (merge_num),
            .axis_dist      (lane_dist[g]),
            .stat           (lane_stat[g])
         );
      end
   endgenerate

   fasdi_merge #(
      .POSITION_BITS (POSITION_BITS)
   ) u_merge (
      .clock         (clock),
      .cmd           (cmd),
      .lane_dist     (lane_dist),
      .lane_active   (lane_active),
      .base_period   (base_period_ff),
      .num           (merge_num),
      .busy          (merge_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_axis0 = rsp_step_ff[0];
   assign rsp_step_axis1 = rsp_step_ff[1];
   assign rsp_step_axis2 = rsp_step_ff[2];
   assign rsp_step_axis3 = rsp_step_ff[3];
   assign rsp_dir_axis0  = rsp_dir_ff[0];
   assign rsp_dir_axis1  = rsp_dir_ff[1];
   assign rsp_dir_axis2  = rsp_dir_ff[2];
   assign rsp_dir_axis3  = rsp_dir_ff[3];
   assign rsp_busy_res   = rsp_busy_ff;

   // a response only appears out of the finishing state
   `FASDI_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH),
      "response without finish")
   // a move never leaves a step pulse behind
   `FASDI_ASSERT(a_move_no_step, (state_ff == ST_COMMIT) |-> (lane_step == '0),
      "step pulse on a move")
   // divider commits once its iteration counter reaches zero
   `FASDI_ASSERT(a_div_exit,
      (state_ff == ST_DIV) && (div_cnt_ff == '0) |=> (state_ff == ST_COMMIT), "divider overrun")
   // reset leaves the sequencer idle with no response pending
   `FASDI_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff,
      "reset state")

endmodule
